>>> src/ifcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcf_pkg: shared definitions for the interleaved flash command block
// Field widths, command and unlock constants, lane modes, sequencer states.
// ----------------------------------------------------------------------------
package ifcf_pkg;

  localparam int ADDR_W    = 18;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 4;

  localparam int IMAGE_ADDR_BITS_DEF = 18;
  localparam int PAGE_BYTES_DEF      = 128;

  localparam logic [CFG_IDX_W-1:0] REG_VENDOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] VENDOR_RST = 8'd31;
  localparam logic [DATA_W-1:0] DEVICE_RST = 8'd213;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [15:0] UNLOCK_ADDR_A = 16'haaaa;
  localparam logic [15:0] UNLOCK_ADDR_B = 16'h5554;

  localparam logic [DATA_W-1:0] CMD_UNLOCK_A = 8'haa;
  localparam logic [DATA_W-1:0] CMD_UNLOCK_B = 8'h55;
  localparam logic [DATA_W-1:0] CMD_PAGE     = 8'ha0;
  localparam logic [DATA_W-1:0] CMD_ID       = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT  = 8'hf0;

  typedef enum logic [2:0] {
    MD_READ,
    MD_UNLOCK1,
    MD_UNLOCK2,
    MD_ID,
    MD_ID_UNLOCK1,
    MD_ID_UNLOCK2,
    MD_BUFFER
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_RESP,
    ST_CMT_RD,
    ST_CMT_WR
  } st_t;

  // unlock address match uses address bits 15..1 only
  function automatic logic at_addr(input logic [ADDR_W-1:0] a, input logic [15:0] t);
    return {a[15:1], 1'b0} == t;
  endfunction

endpackage

>>> src/ifcf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcf_in_if: bus access channel
// One byte read or byte write per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifcf_in_if
  import ifcf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output kind, output address, output write_data,
                  input ready);
  modport sink   (input valid, input kind, input address, input write_data,
                  output ready);
endinterface

>>> src/ifcf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcf_out_if: read data channel
// One read byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifcf_out_if
  import ifcf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

>>> src/ifcf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcf_cfg_if: register write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifcf_cfg_if
  import ifcf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/interleaved_flash_command_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_flash_command_fsm: two interleaved byte-lane flash chips
// Per-lane unlock/command state, page buffer and page commit into the image.
// ----------------------------------------------------------------------------
// After a write is accepted, ready is low in EXEC and high again in IDLE;
//   a read's byte is offered in RESP after EXEC (ID or status) or after EXEC and RDWAIT
//   (image, one registered RAM read), and is held there until out_bus.ready.
// Words are taken one at a time, each finished before the next; the write that fills
//   the last page slot also runs a commit first (buffer read, image write per byte).
// Reset: lane modes go to read mode, ID registers to defaults, then a clearing
//   pass over every lane word zeroes image and page buffer before ready.
module interleaved_flash_command_fsm
  import ifcf_pkg::*;
#(
  parameter int IMAGE_ADDR_BITS = IMAGE_ADDR_BITS_DEF,
  parameter int PAGE_BYTES      = PAGE_BYTES_DEF      // power of two
) (
  input  logic       clk,
  input  logic       rst_n,
  ifcf_in_if.sink    in_bus,
  ifcf_out_if.source out_bus,
  ifcf_cfg_if.sink   cfg_bus
);

  localparam int IAB   = IMAGE_ADDR_BITS;
  localparam int LW    = IAB - 1;              // per-lane image index width
  localparam int PB_W  = $clog2(PAGE_BYTES);
  localparam int LANE_WORDS = 1 << LW;
  localparam logic [PB_W-1:0] PB_LAST = PB_W'(PAGE_BYTES - 1);
  localparam logic [LW-1:0]   CLR_LAST = {LW{1'b1}};

  // storage
  logic [DATA_W-1:0] img0_mem [LANE_WORDS];
  logic [DATA_W-1:0] img1_mem [LANE_WORDS];
  logic [DATA_W-1:0] buf_mem  [2*PAGE_BYTES];

  st_t               st_r, st_nxt;
  mode_t             mode_r [2];
  mode_t             mode_cur, mode_nxt;
  logic [LW-1:0]     clr_r;
  logic [PB_W-1:0]   cnt_r;
  logic [DATA_W-1:0] vendor_r, device_r;

  logic              kind_r;
  logic              lane_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] img_q, buf_q;

  logic [ADDR_W+IAB-1:0] addr_ext;
  logic [IAB-1:0]        iaddr;
  logic [PB_W-1:0]       bidx;

  logic              in_acc;
  logic              img_we0, img_we1, buf_we;
  logic [LW-1:0]     img_wa;
  logic [DATA_W-1:0] img_wd, buf_wd;
  logic [PB_W:0]     buf_wa;
  logic              is_id_mode;

  assign addr_ext = {{IAB{1'b0}}, addr_r};
  assign iaddr    = addr_ext[IAB-1:0];
  assign bidx     = addr_r[PB_W:1];
  assign mode_cur = mode_r[lane_r];
  assign in_acc   = in_bus.valid && in_bus.ready;
  assign is_id_mode = (mode_cur == MD_ID) || (mode_cur == MD_ID_UNLOCK1) ||
                      (mode_cur == MD_ID_UNLOCK2);

  // ---------------- lane command decode ----------------
  always_comb begin
    mode_nxt = mode_cur;
    if (kind_r == KIND_READ) begin
      // a read mid-unlock aborts the sequence
      if (mode_cur == MD_UNLOCK1 || mode_cur == MD_UNLOCK2) begin
        mode_nxt = MD_READ;
      end
    end else begin
      case (mode_cur)
        MD_READ: begin
          if (at_addr(addr_r, UNLOCK_ADDR_A) && data_r == CMD_UNLOCK_A) begin
            mode_nxt = MD_UNLOCK1;
          end
        end
        MD_UNLOCK1: begin
          mode_nxt = (at_addr(addr_r, UNLOCK_ADDR_B) && data_r == CMD_UNLOCK_B) ?
                     MD_UNLOCK2 : MD_READ;
        end
        MD_UNLOCK2: begin
          if (!at_addr(addr_r, UNLOCK_ADDR_A)) begin
            mode_nxt = MD_READ;
          end else if (data_r == CMD_PAGE) begin
            mode_nxt = MD_BUFFER;
          end else if (data_r == CMD_ID) begin
            mode_nxt = MD_ID;
          end else begin
            mode_nxt = MD_READ;
          end
        end
        MD_ID: begin
          if (at_addr(addr_r, UNLOCK_ADDR_A) && data_r == CMD_UNLOCK_A) begin
            mode_nxt = MD_ID_UNLOCK1;
          end
        end
        MD_ID_UNLOCK1: begin
          mode_nxt = (at_addr(addr_r, UNLOCK_ADDR_B) && data_r == CMD_UNLOCK_B) ?
                     MD_ID_UNLOCK2 : MD_ID;
        end
        MD_ID_UNLOCK2: begin
          mode_nxt = (at_addr(addr_r, UNLOCK_ADDR_A) && data_r == CMD_ID_EXIT) ?
                     MD_READ : MD_ID;
        end
        MD_BUFFER: begin
          if (bidx == PB_LAST) begin
            mode_nxt = MD_READ;
          end
        end
        default: mode_nxt = mode_cur;
      endcase
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (kind_r == KIND_READ) begin
          st_nxt = (is_id_mode || mode_cur == MD_BUFFER) ? ST_RESP : ST_RDWAIT;
        end else if (mode_cur == MD_BUFFER && bidx == PB_LAST) begin
          st_nxt = ST_CMT_RD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: st_nxt = ST_RESP;
      ST_RESP: begin
        if (out_bus.ready) st_nxt = ST_IDLE;
      end
      ST_CMT_RD: st_nxt = ST_CMT_WR;
      ST_CMT_WR: begin
        if (cnt_r == PB_LAST) st_nxt = ST_IDLE;
        else                  st_nxt = ST_CMT_RD;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_bus.ready = 1'b0;
    img_we0 = 1'b0;
    img_we1 = 1'b0;
    img_wa  = clr_r;
    img_wd  = '0;
    buf_we  = 1'b0;
    buf_wa  = clr_r[PB_W:0];
    buf_wd  = '0;
    case (st_r)
      ST_CLEAR: begin
        img_we0 = 1'b1;
        img_we1 = 1'b1;
        buf_we  = 1'b1;
      end
      ST_IDLE: in_bus.ready = 1'b1;
      ST_EXEC: begin
        buf_wa = {lane_r, bidx};
        buf_wd = data_r;
        buf_we = (kind_r == KIND_WRITE) && (mode_cur == MD_BUFFER);
      end
      ST_CMT_WR: begin
        // page base in lane words, plus the slot count
        img_wa  = {iaddr[IAB-1:PB_W+1], cnt_r};
        img_wd  = buf_q;
        img_we0 = !lane_r;
        img_we1 = lane_r;
      end
      default: ;
    endcase
  end

  assign out_bus.valid     = (st_r == ST_RESP);
  assign out_bus.read_data = out_data_r;
  assign cfg_bus.ready     = 1'b1;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      mode_r[0] <= MD_READ;
      mode_r[1] <= MD_READ;
      clr_r     <= '0;
      cnt_r     <= '0;
      vendor_r  <= VENDOR_RST;
      device_r  <= DEVICE_RST;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_EXEC) mode_r[lane_r] <= mode_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_EXEC) begin
        cnt_r <= '0;
      end else if (st_r == ST_CMT_WR) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == REG_VENDOR) vendor_r <= cfg_bus.data;
        if (cfg_bus.index == REG_DEVICE) device_r <= cfg_bus.data;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_bus.kind;
      lane_r <= in_bus.address[0];
      addr_r <= in_bus.address;
      data_r <= in_bus.write_data;
    end
    if (st_r == ST_EXEC) begin
      out_data_r <= is_id_mode ? (addr_r[1] ? device_r : vendor_r) : '0;
    end else if (st_r == ST_RDWAIT) begin
      out_data_r <= img_q;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (img_we0) img0_mem[img_wa] <= img_wd;
    if (img_we1) img1_mem[img_wa] <= img_wd;
    img_q <= lane_r ? img1_mem[iaddr[IAB-1:1]] : img0_mem[iaddr[IAB-1:1]];
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    buf_q <= buf_mem[{lane_r, cnt_r}];
  end

  // ---------------- assertions ----------------
  a_out_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (kind_r == KIND_READ && !in_bus.ready))
    else $error("result word without a pending read");

  a_other_lane_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC) |=> (mode_r[~lane_r] == $past(mode_r[~lane_r])))
    else $error("access changed the other lane's mode");

  a_commit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CMT_RD && $past(st_r) == ST_EXEC) |-> (cnt_r == '0))
    else $error("page commit did not start at slot zero");

  a_commit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CMT_RD || st_r == ST_CMT_WR) |-> (mode_r[lane_r] == MD_READ))
    else $error("lane not back in read mode during commit");

endmodule

>>> verif/tb_interleaved_flash_command_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interleaved_flash_command_fsm: self-checking bench for the flash command block
// Drives byte reads and writes through unlock, ID and page-program sequences on
// both lanes, predicts every read byte with a local model of the two lanes, the
// page buffers and the image, and compares each returned word in order.
// ----------------------------------------------------------------------------
module tb_interleaved_flash_command_fsm
  import ifcf_pkg::*;
();

  localparam int PG       = PAGE_BYTES_DEF;
  localparam int IMG_SIZE = 1 << IMAGE_ADDR_BITS_DEF;
  localparam int NPAGES   = IMG_SIZE / (2 * PG);
  localparam int DRAIN    = 2 * PG + 16;
  localparam int HOLD_CYC = 600;
  localparam int LIMIT    = 1000000;
  localparam int PHASE_N  = 330;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = CFG_IDX_W'(15);
  localparam logic [DATA_W-1:0]    STATUS_BUSY = 8'h00;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } bus_op_t;

  logic clk;
  logic rst_n;

  ifcf_in_if  in_bus ();
  ifcf_out_if out_bus ();
  ifcf_cfg_if cfg_bus ();

  interleaved_flash_command_fsm dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // stimulus and bookkeeping
  bus_op_t           bus_q[$];
  bus_op_t           gen_q[$];
  bus_op_t           side_q[$];
  logic [DATA_W-1:0] read_bytes_q[$];
  bus_op_t           drv_op;
  bus_op_t           mon_op;
  logic [DATA_W-1:0] want;
  bit                drv_on = 0;
  bit                in_acc = 0;
  bit                hold_go = 0;
  bit                hold_on = 0;
  int                send_idle = 0;
  int                recv_stall = 0;
  int                push_cnt = 0;
  int                acc_cnt = 0;
  int                n_chk = 0;
  int                n_commit = 0;
  int                n_id = 0;
  int                n_cfg = 0;
  int                err_cnt = 0;
  int                cyc = 0;

  // predictor state
  logic [DATA_W-1:0] id_vendor = VENDOR_RST;
  logic [DATA_W-1:0] id_device = DEVICE_RST;
  mode_t             lane_md[2] = '{MD_READ, MD_READ};
  bit   [DATA_W-1:0] page_buf[2][PG];
  bit   [DATA_W-1:0] flash_mem[IMG_SIZE];

  function automatic bit addr_hit(input logic [ADDR_W-1:0] a, input logic [15:0] t);
    return a[15:1] == t[15:1];
  endfunction

  // advance the lane model by one accepted word; reads queue the byte they return
  task automatic flash_step(input bus_op_t op);
    int unsigned       lane;
    int unsigned       idx;
    int unsigned       base;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] rd;
    a    = op.address;
    d    = op.write_data;
    lane = a[0];
    if (op.kind == KIND_READ) begin
      case (lane_md[lane])
        MD_ID, MD_ID_UNLOCK1, MD_ID_UNLOCK2: rd = a[1] ? id_device : id_vendor;
        MD_BUFFER: rd = STATUS_BUSY;
        MD_UNLOCK1, MD_UNLOCK2: begin
          lane_md[lane] = MD_READ;
          rd = flash_mem[a];
        end
        default: rd = flash_mem[a];
      endcase
      read_bytes_q.push_back(rd);
    end else begin
      case (lane_md[lane])
        MD_READ: begin
          if (addr_hit(a, UNLOCK_ADDR_A) && d == CMD_UNLOCK_A) lane_md[lane] = MD_UNLOCK1;
        end
        MD_UNLOCK1: begin
          lane_md[lane] = (addr_hit(a, UNLOCK_ADDR_B) && d == CMD_UNLOCK_B) ? MD_UNLOCK2 : MD_READ;
        end
        MD_UNLOCK2: begin
          if (!addr_hit(a, UNLOCK_ADDR_A)) begin
            lane_md[lane] = MD_READ;
          end else if (d == CMD_PAGE) begin
            lane_md[lane] = MD_BUFFER;
          end else if (d == CMD_ID) begin
            lane_md[lane] = MD_ID;
            n_id++;
          end else begin
            lane_md[lane] = MD_READ;
          end
        end
        MD_ID: begin
          if (addr_hit(a, UNLOCK_ADDR_A) && d == CMD_UNLOCK_A) lane_md[lane] = MD_ID_UNLOCK1;
        end
        MD_ID_UNLOCK1: begin
          lane_md[lane] = (addr_hit(a, UNLOCK_ADDR_B) && d == CMD_UNLOCK_B) ? MD_ID_UNLOCK2 : MD_ID;
        end
        MD_ID_UNLOCK2: begin
          lane_md[lane] = (addr_hit(a, UNLOCK_ADDR_A) && d == CMD_ID_EXIT) ? MD_READ : MD_ID;
        end
        MD_BUFFER: begin
          idx = (a >> 1) % PG;
          page_buf[lane][idx] = d;
          if (idx == PG - 1) begin
            base = a - (a % (2 * PG));
            for (int i = 0; i < PG; i++)
              flash_mem[(base + 2 * i + lane) % IMG_SIZE] = page_buf[lane][i];
            lane_md[lane] = MD_READ;
            n_commit++;
          end
        end
        default: ;
      endcase
    end
  endtask

  // word builders
  function automatic bus_op_t op_wr(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    bus_op_t op;
    op.kind       = KIND_WRITE;
    op.address    = a;
    op.write_data = d;
    return op;
  endfunction

  function automatic bus_op_t op_rd(input logic [ADDR_W-1:0] a);
    bus_op_t op;
    op.kind       = KIND_READ;
    op.address    = a;
    op.write_data = DATA_W'($urandom);
    return op;
  endfunction

  // unlock address with random bits above the compared range
  function automatic logic [ADDR_W-1:0] unl_addr(input logic [15:0] t, input bit lane);
    logic [1:0] hi;
    hi = 2'($urandom);
    return {hi, t[15:1], lane};
  endfunction

  function automatic logic [ADDR_W-1:0] lane_addr(input bit lane);
    logic [ADDR_W-1:0] a;
    a    = ADDR_W'($urandom);
    a[0] = lane;
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] miss_addr(input logic [15:0] t, input bit lane);
    logic [ADDR_W-1:0] a;
    do begin
      a    = ADDR_W'($urandom);
      a[0] = lane;
    end while (a[15:1] == t[15:1]);
    return a;
  endfunction

  function automatic logic [DATA_W-1:0] bad_byte(input logic [DATA_W-1:0] good);
    logic [DATA_W-1:0] d;
    do d = DATA_W'($urandom); while (d == good);
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(input int pg, input int idx, input bit lane);
    return ADDR_W'(pg * 2 * PG + 2 * idx + lane);
  endfunction

  task automatic gen_unlock(input bit lane, input logic [DATA_W-1:0] cmd);
    gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
    gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
    gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), cmd));
  endtask

  // page program: unlock, buffer some bytes, commit, read back
  task automatic gen_page(input bit lane);
    int pg;
    int n;
    pg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NPAGES - 1) : $urandom_range(0, 7);
    gen_unlock(lane, CMD_PAGE);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, PG - 2) : $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        gen_q.push_back(op_rd(page_addr(pg, $urandom_range(0, PG - 1), lane)));
      gen_q.push_back(op_wr(page_addr(pg, $urandom_range(0, PG - 2), lane), DATA_W'($urandom)));
    end
    // the commit base follows the address of the last slot write
    if ($urandom_range(0, 5) == 0) pg = $urandom_range(0, NPAGES - 1);
    gen_q.push_back(op_wr(page_addr(pg, PG - 1, lane), DATA_W'($urandom)));
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      gen_q.push_back(op_rd(page_addr(pg, $urandom_range(0, PG - 1), lane)));
  endtask

  // ID mode: enter, read codes, maybe a botched exit, then the real exit
  task automatic gen_id(input bit lane);
    int n;
    gen_unlock(lane, CMD_ID);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) gen_q.push_back(op_rd(lane_addr(lane)));
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 2))
        0: gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), bad_byte(CMD_UNLOCK_A)));
        1: begin
          gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
          if ($urandom_range(0, 1))
            gen_q.push_back(op_wr(miss_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
          else
            gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), bad_byte(CMD_UNLOCK_B)));
        end
        default: begin
          gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
          gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
          if ($urandom_range(0, 1))
            gen_q.push_back(op_wr(miss_addr(UNLOCK_ADDR_A, lane), CMD_ID_EXIT));
          else
            gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), bad_byte(CMD_ID_EXIT)));
        end
      endcase
      gen_q.push_back(op_rd(lane_addr(lane)));
    end
    gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
    if ($urandom_range(0, 1)) gen_q.push_back(op_rd(lane_addr(lane)));
    gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
    if ($urandom_range(0, 1)) gen_q.push_back(op_rd(lane_addr(lane)));
    gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_ID_EXIT));
    gen_q.push_back(op_rd(lane_addr(lane)));
  endtask

  // sequences that fall back to read mode partway
  task automatic gen_broken(input bit lane);
    logic [DATA_W-1:0] d;
    case ($urandom_range(0, 5))
      0: gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), bad_byte(CMD_UNLOCK_A)));
      1: begin
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
        gen_q.push_back(op_rd(lane_addr(lane)));
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
      end
      2: begin
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
        gen_q.push_back(op_rd(lane_addr(lane)));
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_PAGE));
      end
      3: begin
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
        if ($urandom_range(0, 1))
          gen_q.push_back(op_wr(miss_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
        else
          gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), bad_byte(CMD_UNLOCK_B)));
      end
      4: begin
        do d = DATA_W'($urandom); while (d == CMD_PAGE || d == CMD_ID);
        gen_unlock(lane, d);
      end
      default: begin
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_A, lane), CMD_UNLOCK_A));
        gen_q.push_back(op_wr(unl_addr(UNLOCK_ADDR_B, lane), CMD_UNLOCK_B));
        gen_q.push_back(op_wr(miss_addr(UNLOCK_ADDR_A, lane),
                              $urandom_range(0, 1) ? CMD_PAGE : CMD_ID));
      end
    endcase
    gen_q.push_back(op_rd(lane_addr(lane)));
  endtask

  task automatic gen_noise(input int n, input bit any_lane, input bit lane);
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      a = any_lane ? ADDR_W'($urandom) : lane_addr(lane);
      if ($urandom_range(0, 1)) gen_q.push_back(op_rd(a));
      else gen_q.push_back(op_wr(a, DATA_W'($urandom)));
    end
  endtask

  task automatic gen_any(input bit lane);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) gen_page(lane);
    else if (r < 65) gen_id(lane);
    else if (r < 85) gen_broken(lane);
    else gen_noise($urandom_range(1, 6), 0, lane);
  endtask

  task automatic enqueue(input bus_op_t op);
    bus_q.push_back(op);
    push_cnt++;
  endtask

  // fill one phase: single-lane sequences, or two lanes woven together
  task automatic fill_random(input int target);
    int  made;
    bit  lane;
    made = 0;
    while (made < target) begin
      lane = $urandom_range(0, 1);
      gen_q.delete();
      gen_any(lane);
      if ($urandom_range(0, 2) == 0) begin
        side_q = gen_q;
        gen_q.delete();
        gen_any(!lane);
      end
      if ($urandom_range(0, 9) == 0) gen_noise($urandom_range(1, 4), 1, lane);
      made += side_q.size() + gen_q.size();
      while (side_q.size() != 0 || gen_q.size() != 0) begin
        if (gen_q.size() == 0 || (side_q.size() != 0 && $urandom_range(0, 1)))
          enqueue(side_q.pop_front());
        else
          enqueue(gen_q.pop_front());
      end
    end
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_VENDOR: id_vendor = val;
      REG_DEVICE: id_device = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // everything accepted and returned, then room for a commit still in flight
  task automatic wait_quiet();
    while (acc_cnt != push_cnt || read_bytes_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // driver: next word or idle once the current one is taken
  always @(negedge clk) begin
    if (drv_on && (!in_bus.valid || in_acc)) begin
      if (bus_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        drv_op = bus_q.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.kind       <= drv_op.kind;
        in_bus.address    <= drv_op.address;
        in_bus.write_data <= drv_op.write_data;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    in_acc = 1'b0;
  end

  always @(negedge clk) begin
    out_bus.ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall);
  end

  // long read-side hold-off so the block backs up onto its input
  initial begin
    forever begin
      wait (hold_go);
      hold_go = 0;
      hold_on = 1;
      repeat (HOLD_CYC) @(posedge clk);
      hold_on = 0;
    end
  end

  // monitor: predict on accepted words, check returned bytes in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        mon_op.kind       = in_bus.kind;
        mon_op.address    = in_bus.address;
        mon_op.write_data = in_bus.write_data;
        flash_step(mon_op);
        in_acc = 1'b1;
        acc_cnt++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (read_bytes_q.size() == 0) begin
          $error("unexpected read word: read_data actual %02h", out_bus.read_data);
          err_cnt++;
        end else begin
          want = read_bytes_q.pop_front();
          if (out_bus.read_data !== want) begin
            $error("read_data mismatch: expected %02h actual %02h", want, out_bus.read_data);
            err_cnt++;
          end
          n_chk++;
        end
      end
    end
  end

  initial begin
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.kind       = KIND_READ;
    in_bus.address    = '0;
    in_bus.write_data = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_VENDOR;
    cfg_bus.data      = '0;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    reg_write(REG_VENDOR, 8'h00);
    reg_write(REG_DEVICE, 8'hff);
    reg_write(REG_SPARE, 8'h5a);   // no such register, must change nothing
    @(posedge clk);
    drv_on = 1;

    // directed: extremes, page commit on lane 0, ID entry and exit on lane 1
    enqueue(op_rd(18'h00000));
    enqueue(op_rd(18'h3ffff));
    enqueue(op_wr(18'h3ffff, 8'hff));
    enqueue(op_wr({2'b11, UNLOCK_ADDR_A[15:1], 1'b0}, CMD_UNLOCK_A));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_B[15:1], 1'b0}, CMD_UNLOCK_B));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b0}, CMD_PAGE));
    enqueue(op_rd(18'h00000));
    enqueue(op_wr(18'h00004, 8'h5a));
    enqueue(op_wr(18'h3fffe, 8'hff));   // last slot, commits into the top page
    enqueue(op_rd(18'h3ff04));
    enqueue(op_rd(18'h3fffe));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b1}, CMD_UNLOCK_A));
    enqueue(op_wr({2'b10, UNLOCK_ADDR_B[15:1], 1'b1}, CMD_UNLOCK_B));
    enqueue(op_wr({2'b01, UNLOCK_ADDR_A[15:1], 1'b1}, CMD_ID));
    enqueue(op_rd(18'h00001));
    enqueue(op_rd(18'h00003));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b1}, CMD_UNLOCK_A));
    enqueue(op_rd(18'h3ffff));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_B[15:1], 1'b1}, CMD_UNLOCK_B));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b1}, CMD_ID_EXIT));
    enqueue(op_rd(18'h3ffff));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b0}, CMD_UNLOCK_A));
    enqueue(op_rd(18'h3ff04));          // aborts the unlock
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b0}, CMD_UNLOCK_A));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_B[15:1], 1'b0}, CMD_UNLOCK_B));
    enqueue(op_wr({2'b00, UNLOCK_ADDR_A[15:1], 1'b0}, 8'h00));
    enqueue(op_rd(18'h3fffe));

    for (int ph = 1; ph <= 5; ph++) begin
      wait_quiet();
      case (ph)
        1: begin
          reg_write(REG_VENDOR, 8'hff);
          reg_write(REG_DEVICE, 8'h00);
        end
        4: begin
          reg_write(REG_VENDOR, VENDOR_RST);
          reg_write(REG_DEVICE, DEVICE_RST);
        end
        default: begin
          reg_write(REG_VENDOR, DATA_W'($urandom));
          reg_write(REG_DEVICE, DATA_W'($urandom));
        end
      endcase
      @(posedge clk);
      case (ph)
        1: begin send_idle = 0;  recv_stall = 0;  hold_go = 1; end
        2: begin send_idle = 84; recv_stall = 0;  end
        3: begin send_idle = 0;  recv_stall = 84; end
        4: begin send_idle = 19; recv_stall = 19; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      fill_random(PHASE_N);
    end

    wait_quiet();
    $display("covered %0d bus words: %0d read bytes checked, %0d page commits, %0d ID entries",
             acc_cnt, n_chk, n_commit, n_id);
    $display("%0d register writes, idle and stall mixes on both channels, one long hold-off",
             n_cfg);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/ifcf_pkg.sv
src/ifcf_in_if.sv
src/ifcf_out_if.sv
src/ifcf_cfg_if.sv
src/interleaved_flash_command_fsm.sv
verif/tb_interleaved_flash_command_fsm.sv
